// ===== hdl/tmwf_pkg.sv =====
package tmwf_pkg;

    localparam int CHANNELS = 32;
    localparam int WINDOW   = 8;
    localparam int TRIM     = 2;

    localparam int CHAN_W   = 5;
    localparam int SAMPLE_W = 12;

    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int J_W      = $clog2(WINDOW);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

    localparam int DIV      = WINDOW - TRIM;
    localparam int SHIFT    = SUM_W + $clog2(DIV + 1);
    localparam int MULT_W   = SHIFT + 1;
    localparam int PROD_W   = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT =
        MULT_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TRIM = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic first;
        logic acc;
        logic trim;
        logic mul;
    } stats_ctl_t;

endpackage

// ===== hdl/tmwf_ram.sv =====
module tmwf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/tmwf_stats.sv =====
module tmwf_stats (
    input  logic                          aclk,
    input  tmwf_pkg::stats_ctl_t          ctl,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] elem,
    output logic [tmwf_pkg::SAMPLE_W-1:0] result
);

    import tmwf_pkg::*;

    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    trim_reg, trim_next;
    logic                eq_reg, eq_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    always_comb begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        sum_next  = sum_reg;
        trim_next = trim_reg;
        eq_next   = eq_reg;
        prod_next = prod_reg;
        if (ctl.acc) begin
            if (ctl.first) begin
                lo_next  = elem;
                hi_next  = elem;
                sum_next = SUM_W'(elem);
            end else begin
                if (elem < lo_reg) begin
                    lo_next = elem;
                end
                if (elem > hi_reg) begin
                    hi_next = elem;
                end
                sum_next = sum_reg + SUM_W'(elem);
            end
        end
        if (ctl.trim) begin
            trim_next = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
            eq_next   = (lo_reg == hi_reg);
        end
        if (ctl.mul) begin
            prod_next = PROD_W'(trim_reg) * PROD_W'(MULT);
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        sum_reg  <= sum_next;
        trim_reg <= trim_next;
        eq_reg   <= eq_next;
        prod_reg <= prod_next;
    end

    // all entries equal: pass the oldest, which the min tracker holds
    assign result = eq_reg ? lo_reg : prod_reg[SHIFT +: SAMPLE_W];

endmodule

// ===== hdl/trimmed_mean_window_filter_core.sv =====
// Channel   | Direction | Handshake         | Payload
// s_        | in        | s_valid / s_ready | s_channel[4:0], s_sample[11:0]
// m_        | out       | m_valid / m_ready | m_filtered[11:0]
//
// An item walks the window memory: each kept entry is read and written back one slot
// down, the new sample goes into the top slot, then trim, multiply, output.
// Reset clears a valid bit per channel row; a row never written reads as zeros.
// A held result stalls the block only in its final cycle; input is taken in idle.
module trimmed_mean_window_filter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmwf_pkg::CHAN_W-1:0]   s_channel,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tmwf_pkg::SAMPLE_W-1:0] m_filtered
);

    import tmwf_pkg::*;

    state_t              state_reg, state_next;
    logic [J_W-1:0]      j_reg, j_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                rv_reg, rv_next;
    logic                zero_reg, zero_next;
    logic [CHANNELS-1:0] row_valid_reg, row_valid_next;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_filtered_reg, m_filtered_next;

    logic                ch_ok;
    logic [ADDR_W-1:0]   in_base;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] elem;
    logic                last;
    stats_ctl_t          ctl;
    logic [SAMPLE_W-1:0] result;

    assign ch_ok   = (32'(s_channel) < CHANNELS);
    assign in_base = ADDR_W'(32'(s_channel) * WINDOW);
    assign last    = (j_reg == J_W'(WINDOW - 1));
    assign elem    = last ? smp_reg : (rv_reg ? ram_rdata : '0);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    always_comb begin
        state_next      = state_reg;
        j_next          = j_reg;
        base_next       = base_reg;
        ch_next         = ch_reg;
        smp_next        = smp_reg;
        rv_next         = rv_reg;
        zero_next       = zero_reg;
        row_valid_next  = row_valid_reg;
        m_valid_next    = m_valid_reg;
        m_filtered_next = m_filtered_reg;
        ram_we          = 1'b0;
        ram_waddr       = base_reg + ADDR_W'(j_reg);
        ram_re          = 1'b0;
        ram_raddr       = in_base + ADDR_W'(1);
        ctl             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    j_next    = '0;
                    base_next = in_base;
                    ch_next   = CH_W'(s_channel);
                    smp_next  = s_sample;
                    zero_next = !ch_ok;
                    if (ch_ok) begin
                        rv_next    = row_valid_reg[CH_W'(s_channel)];
                        ram_re     = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // shift entry down by one slot while gathering min, max and sum
                ram_we    = 1'b1;
                ctl.acc   = 1'b1;
                ctl.first = (j_reg == '0);
                if (32'(j_reg) < WINDOW - 2) begin
                    ram_re    = 1'b1;
                    ram_raddr = base_reg + ADDR_W'(32'(j_reg) + 2);
                end
                if (last) begin
                    row_valid_next[ch_reg] = 1'b1;
                    state_next             = ST_TRIM;
                end else begin
                    j_next = j_reg + J_W'(1);
                end
            end
            ST_TRIM: begin
                ctl.trim   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctl.mul    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = zero_reg ? '0 : result;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        j_reg          <= j_next;
        base_reg       <= base_next;
        ch_reg         <= ch_next;
        smp_reg        <= smp_next;
        rv_reg         <= rv_next;
        zero_reg       <= zero_next;
        m_filtered_reg <= m_filtered_next;
    end

    tmwf_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_window_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(elem),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tmwf_stats u_stats (
        .aclk  (aclk),
        .ctl   (ctl),
        .elem  (elem),
        .result(result)
    );

endmodule
